>>> sv/msu_pkg.sv
// ----------------------------------------------------------------------------
// msu_pkg
// Request and response types and opcodes shared by the sorted-union block.
// ----------------------------------------------------------------------------
package msu_pkg;

	// Request opcodes.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_MERGE  = 1'b1;

	// One request: append doc_id to a list, or merge and clear all lists.
	typedef struct packed {
		logic        opcode;
		logic [2:0]  list_index;
		logic [31:0] doc_id;
	} req_t;

	// One result of a merge run.
	typedef struct packed {
		logic [31:0] doc_id_out;
		logic        is_last;
		logic        is_empty;
		logic        dropped;
	} rsp_t;

endpackage

>>> sv/msu_ram.sv
// ----------------------------------------------------------------------------
// msu_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module msu_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> sv/multiway_sorted_union.sv
// An append is written to the list store in the cycle after its acceptance.
// Throughput: appends are taken one per cycle, back to back, while no merge runs.
// A merge holds the request side for its whole run: a pass visits each list in
// turn, reads its table entry and its head, and walks its entries; there is one
// pass per distinct id plus one, then the final result. A stalled output lengthens it.
// Reset clears all lists at once through per-list valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// multiway_sorted_union
// Keeps NUM_LISTS ascending lists of document ids in a shared entry store and,
// on a merge request, emits the duplicate-free union in ascending order.
// ----------------------------------------------------------------------------
module multiway_sorted_union #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  msu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output msu_pkg::rsp_t rsp
);

	// Widths: list index, fill/cursor count and entry store address.
	localparam int LW    = $clog2(NUM_LISTS);
	localparam int CW    = $clog2(LIST_DEPTH + 1);
	localparam int ENTRIES = NUM_LISTS * LIST_DEPTH;
	localparam int EW    = $clog2(ENTRIES);

	localparam logic [CW-1:0] DEPTH_C   = CW'(LIST_DEPTH);
	localparam logic [EW-1:0] STEP_C    = EW'(LIST_DEPTH);
	localparam logic [LW-1:0] LAST_LIST = LW'(NUM_LISTS - 1);

	// Per-list bookkeeping held in the list table: how many ids the list holds
	// and, during a merge, how far the merge has read into it.
	typedef struct packed {
		logic [CW-1:0] fill;
		logic [CW-1:0] cursor;
	} meta_t;

	localparam int MW = $bits(meta_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_META,
		S_HEAD,
		S_WALK,
		S_PASS,
		S_FINAL
	} state_t;

	// ------------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------------
	state_t         state_q;

	// Append pipeline stage and the forwarding copy of the last table write.
	logic           app_vld_s1;
	logic [LW-1:0]  idx_s1;
	logic [31:0]    id_s1;
	logic           fwd_vld_q;
	logic [LW-1:0]  fwd_idx_q;
	logic [CW-1:0]  fwd_fill_q;
	logic           drop_seen_q;

	// A list whose valid bit is clear reads as empty with its cursor at zero.
	logic [NUM_LISTS-1:0] meta_vld_q;

	// Merge datapath.
	logic [LW-1:0]  l_q;
	logic [EW-1:0]  base_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  cur_q;
	logic           min_vld_q;
	logic [31:0]    min_q;
	logic           have_q;
	logic [31:0]    last_q;

	logic           rsp_vld_q;
	msu_pkg::rsp_t  rsp_q;

	// Memory ports.
	logic           meta_we;
	logic [LW-1:0]  meta_waddr;
	meta_t          meta_wdata;
	logic [LW-1:0]  meta_raddr;
	logic [MW-1:0]  meta_rbits;
	meta_t          meta_rd;

	logic           ent_we;
	logic [EW-1:0]  ent_waddr;
	logic [EW-1:0]  ent_raddr;
	logic [31:0]    ent_rd;

	// Combinational control.
	logic           req_go;
	logic           app_go;
	logic           merge_go;
	logic [LW-1:0]  idx_in;
	logic [CW-1:0]  fill_cur;
	logic           app_full;
	logic           app_we;
	logic [CW-1:0]  head_fill;
	logic [CW-1:0]  head_cur;
	logic           walk_skip;
	logic [CW-1:0]  walk_cur;
	logic           walk_more;
	logic           m_we;
	logic [CW-1:0]  m_cur;
	logic           last_list;
	logic           out_free;
	logic           fin_go;
	logic           rsp_load;

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	// Requests are taken only while no merge is running. An append to a list
	// index beyond the configured number of lists is accepted and discarded.
	assign req_stall = (state_q != S_IDLE);
	assign req_go    = req_valid && !req_stall;
	assign merge_go  = req_go && (req.opcode == msu_pkg::OP_MERGE);
	assign app_go    = req_go && (req.opcode == msu_pkg::OP_APPEND)
	                   && (32'(req.list_index) < NUM_LISTS);
	assign idx_in    = LW'(req.list_index);

	// ------------------------------------------------------------------------
	// Storage
	// ------------------------------------------------------------------------
	// The list table is read every cycle: at the list being visited in S_META,
	// and otherwise at the incoming request's list, so that the fill count is
	// ready when the append reaches stage 1.
	assign meta_raddr = (state_q == S_META) ? l_q : idx_in;
	assign meta_rd    = meta_rbits;

	msu_ram #(
		.DEPTH (NUM_LISTS),
		.WIDTH (MW)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rbits)
	);

	msu_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (32)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (id_s1),
		.raddr (ent_raddr),
		.rdata (ent_rd)
	);

	// ------------------------------------------------------------------------
	// Append path
	// ------------------------------------------------------------------------
	// The fill count read for stage 1 was captured at the same edge as the
	// previous append's table write, so a back-to-back append to the same list
	// takes the count from the forwarding register instead.
	always_comb begin
		if (fwd_vld_q && (fwd_idx_q == idx_s1)) begin
			fill_cur = fwd_fill_q;
		end else if (meta_vld_q[idx_s1]) begin
			fill_cur = meta_rd.fill;
		end else begin
			fill_cur = '0;
		end
	end

	// A full list drops the id and raises the sticky flag reported by the merge.
	assign app_full  = (fill_cur >= DEPTH_C);
	assign app_we    = app_vld_s1 && !app_full;
	assign ent_we    = app_we;
	assign ent_waddr = EW'(idx_s1 * LIST_DEPTH) + EW'(fill_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_vld_s1  <= 1'b0;
			fwd_vld_q   <= 1'b0;
			drop_seen_q <= 1'b0;
		end else begin
			app_vld_s1 <= app_go;
			fwd_vld_q  <= app_we;
			if (fin_go) begin
				drop_seen_q <= 1'b0;
			end else if (app_vld_s1 && app_full) begin
				drop_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= idx_in;
		id_s1      <= req.doc_id;
		fwd_idx_q  <= idx_s1;
		fwd_fill_q <= fill_cur + 1'b1;
	end

	// The end of a merge empties every list at once by dropping its valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
		end else if (fin_go) begin
			meta_vld_q <= '0;
		end else if (app_we) begin
			meta_vld_q[idx_s1] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Merge datapath
	// ------------------------------------------------------------------------
	// Each pass visits every list in turn. It first skips the entries equal to
	// the id chosen by the previous pass, then offers the list's new head to a
	// running minimum. The minimum of a pass is the next id of the union.
	assign head_fill = meta_vld_q[l_q] ? meta_rd.fill : '0;
	assign head_cur  = meta_vld_q[l_q] ? meta_rd.cursor : '0;
	assign walk_skip = have_q && (ent_rd == last_q);
	assign walk_cur  = cur_q + 1'b1;
	assign walk_more = walk_skip && (walk_cur < fill_q);
	assign last_list = (l_q == LAST_LIST);

	// The walk reads ahead one entry per cycle; the address follows the cursor.
	assign ent_raddr = base_q + EW'((state_q == S_WALK) ? walk_cur : head_cur);

	// When the walk over a list ends, its cursor goes back to the table.
	assign m_we  = (state_q == S_WALK) && !walk_more;
	assign m_cur = walk_skip ? walk_cur : cur_q;

	always_comb begin
		meta_we    = app_we || m_we;
		meta_waddr = m_we ? l_q : idx_s1;
		if (m_we) begin
			meta_wdata.fill   = fill_q;
			meta_wdata.cursor = m_cur;
		end else begin
			meta_wdata.fill   = fill_cur + 1'b1;
			meta_wdata.cursor = '0;
		end
	end

	// The output register may be reloaded when empty or when it is being taken.
	assign out_free = !rsp_vld_q || !rsp_stall;
	assign fin_go   = (state_q == S_FINAL) && out_free;

	// A result is loaded when a pass finds a new id while one is held, or when
	// the run closes.
	assign rsp_load = fin_go || ((state_q == S_PASS) && min_vld_q && have_q
	                  && (min_q != last_q) && out_free);

	// ------------------------------------------------------------------------
	// Merge sequencer and output register
	// ------------------------------------------------------------------------
	// A found id is held in last_q until the next distinct id turns up, since
	// only then is it known not to be the final result of the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			l_q       <= '0;
			base_q    <= '0;
			fill_q    <= '0;
			cur_q     <= '0;
			min_vld_q <= 1'b0;
			min_q     <= '0;
			have_q    <= 1'b0;
			last_q    <= '0;
			rsp_vld_q <= 1'b0;
			rsp_q     <= '0;
		end else begin
			if (rsp_vld_q && !rsp_stall && !rsp_load) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (merge_go) begin
						l_q       <= '0;
						base_q    <= '0;
						min_vld_q <= 1'b0;
						have_q    <= 1'b0;
						state_q   <= S_META;
					end
				end
				S_META: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					fill_q <= head_fill;
					cur_q  <= head_cur;
					if (head_cur < head_fill) begin
						state_q <= S_WALK;
					end else if (last_list) begin
						state_q <= S_PASS;
					end else begin
						l_q     <= l_q + 1'b1;
						base_q  <= base_q + STEP_C;
						state_q <= S_META;
					end
				end
				S_WALK: begin
					if (walk_more) begin
						cur_q <= walk_cur;
					end else begin
						if (!walk_skip && (!min_vld_q || (ent_rd < min_q))) begin
							min_q     <= ent_rd;
							min_vld_q <= 1'b1;
						end
						if (last_list) begin
							state_q <= S_PASS;
						end else begin
							l_q     <= l_q + 1'b1;
							base_q  <= base_q + STEP_C;
							state_q <= S_META;
						end
					end
				end
				S_PASS: begin
					if (!min_vld_q) begin
						state_q <= S_FINAL;
					end else if (!have_q || (min_q == last_q)) begin
						have_q    <= 1'b1;
						last_q    <= min_q;
						l_q       <= '0;
						base_q    <= '0;
						min_vld_q <= 1'b0;
						state_q   <= S_META;
					end else if (out_free) begin
						rsp_q.doc_id_out <= last_q;
						rsp_q.is_last    <= 1'b0;
						rsp_q.is_empty   <= 1'b0;
						rsp_q.dropped    <= drop_seen_q;
						rsp_vld_q        <= 1'b1;
						last_q           <= min_q;
						l_q              <= '0;
						base_q           <= '0;
						min_vld_q        <= 1'b0;
						state_q          <= S_META;
					end
				end
				S_FINAL: begin
					// With nothing found at all, a single empty result closes the run.
					if (out_free) begin
						rsp_q.doc_id_out <= have_q ? last_q : '0;
						rsp_q.is_last    <= 1'b1;
						rsp_q.is_empty   <= !have_q;
						rsp_q.dropped    <= drop_seen_q;
						rsp_vld_q        <= 1'b1;
						have_q           <= 1'b0;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

>>> bench/tb_multiway_sorted_union.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_multiway_sorted_union
// Drives append and merge requests into the sorted-union block, predicts every
// merge result from its own copy of the lists, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_multiway_sorted_union;

	localparam int LISTS        = 8;
	localparam int DEPTH        = 8;
	localparam int RANDOM_ITEMS = 108;
	// Bar the hold-off, neither side idles with fewer than this many left to send.
	localparam int TAIL_ITEMS   = 25;
	// The long receiver hold-off, and the point at which it starts.
	localparam int HOLD_OFF     = 300;
	localparam int HOLD_AFTER   = 40;
	// Quiet stretches come from merge passes and receiver gaps between results;
	// the hold-off is the longest quiet stretch of all.
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	msu_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	msu_pkg::rsp_t rsp;

	// Requests waiting to be sent, and the merge results still owed by the block.
	msu_pkg::req_t pending_reqs[$];
	msu_pkg::rsp_t expected_results[$];

	// The testbench's own copy of the lists and the sticky drop flag.
	logic [31:0] list_ids[LISTS][DEPTH];
	int          list_len[LISTS];
	bit          drop_flag;

	int fail_count   = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	bit req_taken    = 1'b0;
	bit rsp_taken    = 1'b0;

	multiway_sorted_union DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Updates the list copy for one accepted request. A merge works out the
	// whole run of results at once: each step takes the smallest head over all
	// lists, emits it unless it repeats the previous id, and moves past that id
	// in every list. This also covers lists that were not appended in order.
	function automatic void predict_union(msu_pkg::req_t r);
		int            cur[LISTS];
		logic [31:0]   next_id;
		bit            found;
		bit            scanning;
		bit            have_held;
		msu_pkg::rsp_t held;
		if (r.opcode == msu_pkg::OP_APPEND) begin
			if (int'(r.list_index) < LISTS) begin
				if (list_len[r.list_index] >= DEPTH) begin
					drop_flag = 1'b1;
				end else begin
					list_ids[r.list_index][list_len[r.list_index]] = r.doc_id;
					list_len[r.list_index]++;
				end
			end
		end else begin
			for (int l = 0; l < LISTS; l++)
				cur[l] = 0;
			have_held = 1'b0;
			held      = '0;
			scanning  = 1'b1;
			while (scanning) begin
				found   = 1'b0;
				next_id = '0;
				for (int l = 0; l < LISTS; l++) begin
					if (cur[l] < list_len[l] && (!found || list_ids[l][cur[l]] < next_id)) begin
						found   = 1'b1;
						next_id = list_ids[l][cur[l]];
					end
				end
				if (!found) begin
					scanning = 1'b0;
				end else begin
					// The previous result is only queued once we know it is not the last.
					if (!have_held || next_id != held.doc_id_out) begin
						if (have_held)
							expected_results = {expected_results, held};
						held.doc_id_out = next_id;
						held.is_last    = 1'b0;
						held.is_empty   = 1'b0;
						held.dropped    = drop_flag;
						have_held       = 1'b1;
					end
					for (int l = 0; l < LISTS; l++)
						while (cur[l] < list_len[l] && list_ids[l][cur[l]] == next_id)
							cur[l]++;
				end
			end
			if (have_held) begin
				held.is_last = 1'b1;
			end else begin
				// Every list was empty: a single flagged result with a zero id.
				held.doc_id_out = '0;
				held.is_last    = 1'b1;
				held.is_empty   = 1'b1;
				held.dropped    = drop_flag;
			end
			expected_results = {expected_results, held};
			for (int l = 0; l < LISTS; l++)
				list_len[l] = 0;
			drop_flag = 1'b0;
		end
	endfunction

	function automatic void queue_append(int l, logic [31:0] id);
		msu_pkg::req_t r;
		r.opcode     = msu_pkg::OP_APPEND;
		r.list_index = l[2:0];
		r.doc_id     = id;
		pending_reqs = {pending_reqs, r};
	endfunction

	// The index and id of a merge request carry no meaning, so they are random.
	function automatic void queue_merge();
		msu_pkg::req_t r;
		r.opcode     = msu_pkg::OP_MERGE;
		r.list_index = 3'($urandom_range(0, 7));
		r.doc_id     = $urandom;
		pending_reqs = {pending_reqs, r};
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Request driver: a request stays on the bus until it is taken, and gaps
	// are only opened between requests, never under one.
	always @(negedge clk) begin : drive_requests
		msu_pkg::req_t next_req;
		logic          next_valid;
		bit            tail;
		next_req   = req;
		next_valid = req_valid;
		tail       = pending_reqs.size() < TAIL_ITEMS;
		if (tail)
			send_gap = 0;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!req_valid || req_taken) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_reqs.size() > 0) begin
				if (!tail && $urandom_range(0, 9) == 0) begin
					// This cycle is the first of the gap.
					send_gap = $urandom_range(1, 13) - 1;
				end else begin
					next_req   = pending_reqs.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		req_valid <= next_valid;
		req       <= next_req;
	end

	// Result receiver: short random stalls, and once in the run a long hold-off
	// so that a merge backs up and the block stops taking further requests.
	always @(negedge clk) begin : drive_result_stall
		logic next_stall;
		bit   tail;
		next_stall = 1'b0;
		tail       = pending_reqs.size() < TAIL_ITEMS;
		if (!arst_n) begin
			next_stall = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done  = 1'b1;
			hold_left  = HOLD_OFF - 1;
			next_stall = 1'b1;
		end else if (tail) begin
			recv_gap = 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			next_stall = 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			recv_gap   = $urandom_range(1, 13) - 1;
			next_stall = 1'b1;
		end
		rsp_stall <= next_stall;
	end

	// Everything is sampled at the rising edge. A request taken here is folded
	// into the prediction before any result of the same edge is checked.
	always @(posedge clk) begin : observe
		msu_pkg::rsp_t want;
		req_taken = arst_n && req_valid && !req_stall;
		rsp_taken = arst_n && rsp_valid && !rsp_stall;
		if (req_taken)
			predict_union(req);
		if (rsp_taken) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: doc_id_out %0h", rsp.doc_id_out);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("doc_id_out", want.doc_id_out, rsp.doc_id_out);
				check_field("is_last", 32'(want.is_last), 32'(rsp.is_last));
				check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
				check_field("dropped", 32'(want.dropped), 32'(rsp.dropped));
			end
		end
		// Watchdog: a long run of cycles in which nothing is taken on either side.
		if (!arst_n || req_taken || rsp_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multiway_sorted_union: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] gen_last[LISTS];
		logic [31:0] base;
		int          random_start;
		int          pick;
		int          n;
		int          l;
		bit          full_done;
		for (int i = 0; i < LISTS; i++)
			list_len[i] = 0;
		drop_flag = 1'b0;
		full_done = 1'b0;

		// Merge with every list empty.
		queue_merge();
		// Extreme ids, and the same id held in two lists.
		queue_append(0, 32'h0000_0000);
		queue_append(7, 32'hFFFF_FFFF);
		queue_append(3, 32'h8000_0000);
		queue_append(5, 32'h0000_0000);
		queue_merge();
		// Fill one list and append once more, so the drop flag rides on the run;
		// another list repeats an id both of its own and of the full list.
		for (int k = 0; k < DEPTH + 1; k++)
			queue_append(2, 32'd10 + k);
		queue_append(6, 32'd12);
		queue_append(6, 32'd12);
		queue_merge();
		// A list appended out of order.
		queue_append(1, 32'd5);
		queue_append(1, 32'd3);
		queue_append(4, 32'd4);
		queue_merge();

		// Random batches, each closed by a merge. Most batches are ascending
		// lists sharing a narrow range of ids, so duplicates across lists are
		// common; the rest overflow a list, scatter random ids, or merge nothing.
		random_start = pending_reqs.size();
		while (pending_reqs.size() - random_start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			base = $urandom;
			for (int i = 0; i < LISTS; i++)
				gen_last[i] = base + $urandom_range(0, 4);
			if (!full_done && pending_reqs.size() - random_start > 30) begin
				// Every list full with distinct ids: the longest possible run.
				full_done = 1'b1;
				for (int i = 0; i < LISTS; i++)
					for (int k = 0; k < DEPTH; k++)
						queue_append(i, base + LISTS * k + i);
			end else if (pick < 55) begin
				n = $urandom_range(1, 16);
				repeat (n) begin
					l = $urandom_range(0, LISTS - 1);
					queue_append(l, gen_last[l]);
					gen_last[l] += $urandom_range(1, 3);
				end
			end else if (pick < 75) begin
				l = $urandom_range(0, LISTS - 1);
				n = $urandom_range(DEPTH + 1, DEPTH + 3);
				repeat (n) begin
					queue_append(l, gen_last[l]);
					gen_last[l] += $urandom_range(1, 3);
				end
				n = $urandom_range(0, 3);
				repeat (n) begin
					l = $urandom_range(0, LISTS - 1);
					queue_append(l, gen_last[l]);
					gen_last[l] += $urandom_range(1, 3);
				end
			end else if (pick < 92) begin
				n = $urandom_range(1, 12);
				repeat (n)
					queue_append($urandom_range(0, LISTS - 1), $urandom);
			end
			queue_merge();
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0 && !req_valid && expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("multiway_sorted_union: match");
		else
			$display("multiway_sorted_union: mismatch");
		$finish;
	end

endmodule
